// ----- design/pcsp_pkg.sv -----
// Shared types and constant tables for the plane/cube slice block.
`default_nettype none

package pcsp_pkg;

	localparam int CW    = 17;	// coordinate field width
	localparam int NW    = 16;	// normal component width
	localparam int TW    = 8;	// tag width
	localparam int NEDGE = 12;
	localparam int NPTS  = 6;	// max crossings of a plane with a cube

	localparam logic [3:0] LAST_EDGE   = 4'd11;
	localparam logic [2:0] LAST_CORNER = 3'd7;
	localparam logic [1:0] LAST_AXIS   = 2'd2;

	// cube edges, corner numbering as in the corner masks below
	localparam logic [2:0] EDGE_FROM [NEDGE] = '{3'd0, 3'd3, 3'd7, 3'd4, 3'd0, 3'd4,
		3'd5, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3};
	localparam logic [2:0] EDGE_TO [NEDGE] = '{3'd1, 3'd2, 3'd6, 3'd5, 3'd3, 3'd7,
		3'd6, 3'd2, 3'd4, 3'd5, 3'd6, 3'd7};
	localparam logic [1:0] EDGE_AXIS [NEDGE] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
		2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2};

	// bit c set: corner c sits at 1.0 on that axis
	localparam logic [7:0] CORNER_MASK [3] = '{8'b0110_0110, 8'b1100_1100, 8'b1111_0000};

	typedef struct packed {
		logic       load;		// capture input transaction
		logic       mac;		// issue one distance product
		logic       mac_first;
		logic       mac_last;
		logic [2:0] corner;
		logic [1:0] axis;
		logic [3:0] edge_idx;
		logic       rd;		// read both end distances of edge_idx
		logic       div_init;
		logic       div_step;
		logic       pt_wr;		// store crossing point of edge_idx
		logic       emit;		// pick next vertex into output register
		logic       emit_first;
		logic       emit_last;
	} pcsp_cmd_t;

	typedef struct packed {
		logic       differ;	// ends of edge_idx on opposite sides
		logic       out_free;
		logic [2:0] cnt;		// points found so far
	} pcsp_stat_t;

endpackage

`default_nettype wire

// ----- design/pcsp_dp.sv -----
// Datapath: corner distances, edge division, point store, chaining pick, output register.
`default_nettype none

module pcsp_dp import pcsp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pcsp_cmd_t            cmd,
	output pcsp_stat_t                st,
	input  wire logic [TW-1:0]        plane_number,
	input  wire logic [CW-1:0]        origin_x,
	input  wire logic [CW-1:0]        origin_y,
	input  wire logic [CW-1:0]        origin_z,
	input  wire logic signed [NW-1:0] normal_x,
	input  wire logic signed [NW-1:0] normal_y,
	input  wire logic signed [NW-1:0] normal_z,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic [TW-1:0]             plane_tag,
	output logic [CW-1:0]             vertex_x,
	output logic [CW-1:0]             vertex_y,
	output logic [CW-1:0]             vertex_z,
	output logic                      last_vertex
);

	localparam int BW  = (FRAC_BITS > CW ? FRAC_BITS : CW) + 2;	// corner offset
	localparam int PRW = BW + NW;					// product
	localparam int DW  = PRW + 2;					// distance
	localparam int PW  = FRAC_BITS + 1;				// point coordinate

	localparam logic signed [BW-1:0] ONE_T =
		{{(BW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PW-1:0] ONE_P = {1'b1, {FRAC_BITS{1'b0}}};

	logic [TW-1:0]        tag_q;
	logic [CW-1:0]        org_q [3];
	logic signed [NW-1:0] nrm_q [3];

	// distance products
	logic signed [NW-1:0]  n_sel;
	logic signed [BW-1:0]  o_ext;
	logic signed [BW-1:0]  term;
	logic signed [PRW-1:0] prod_c;
	logic signed [PRW-1:0] prod_s1;
	logic                  mac_v_s1, first_s1, last_s1;
	logic [2:0]            corner_s1;
	logic signed [DW-1:0]  acc_q, acc_sum;
	logic [DW-1:0]         dist_mem [8];
	logic [7:0]            outside_q;

	// division
	logic [DW-1:0]   da_q, db_q, ma, mb;
	logic [DW:0]     r_q, s_q;
	logic [DW+1:0]   r2, r2_sub;
	logic            ge;
	logic [PW-1:0]   q_q, weight;
	logic            mbz_q;

	// points and chaining
	logic [PW-1:0]   pts_q [NPTS][3];
	logic [PW-1:0]   cur_q [3];
	logic [2:0]      cnt_q;
	logic [NPTS-1:0] used_q, avail, pick_vec;
	logic [NPTS-1:0] m [3];
	logic [2:0]      face;
	logic [2:0]      sel;
	logic            out_valid_q;

	assign n_sel  = nrm_q[cmd.axis];
	assign o_ext  = BW'(org_q[cmd.axis]);
	assign term   = CORNER_MASK[cmd.axis][cmd.corner] ? (ONE_T - o_ext) : -o_ext;
	assign prod_c = PRW'(n_sel) * PRW'(term);

	assign acc_sum = (first_s1 ? DW'(0) : acc_q) + DW'(prod_s1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q    <= plane_number;
			org_q[0] <= origin_x;
			org_q[1] <= origin_y;
			org_q[2] <= origin_z;
			nrm_q[0] <= normal_x;
			nrm_q[1] <= normal_y;
			nrm_q[2] <= normal_z;
		end
		prod_s1   <= prod_c;
		first_s1  <= cmd.mac_first;
		last_s1   <= cmd.mac_last;
		corner_s1 <= cmd.corner;
		if (mac_v_s1) begin
			acc_q <= acc_sum;
			if (last_s1) begin
				dist_mem[corner_s1]  <= acc_sum;
				outside_q[corner_s1] <= ~acc_sum[DW-1];
			end
		end
		if (cmd.rd) begin
			da_q <= dist_mem[EDGE_FROM[cmd.edge_idx]];
			db_q <= dist_mem[EDGE_TO[cmd.edge_idx]];
		end
	end

	assign st.differ = outside_q[EDGE_FROM[cmd.edge_idx]] ^ outside_q[EDGE_TO[cmd.edge_idx]];

	// restoring division, one quotient bit a cycle
	assign ma     = da_q[DW-1] ? -da_q : da_q;
	assign mb     = db_q[DW-1] ? -db_q : db_q;
	assign r2     = {r_q, 1'b0};
	assign ge     = r2 >= {1'b0, s_q};
	assign r2_sub = r2 - {1'b0, s_q};
	assign weight = mbz_q ? ONE_P : q_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			r_q   <= {1'b0, ma};
			s_q   <= {1'b0, ma} + {1'b0, mb};
			q_q   <= '0;
			mbz_q <= (mb == '0);
		end else if (cmd.div_step) begin
			r_q <= ge ? r2_sub[DW:0] : r2[DW:0];
			q_q <= {q_q[PW-2:0], ge};
		end
		if (cmd.pt_wr && cnt_q != 3'(NPTS)) begin
			for (int k = 0; k < 3; k++) begin
				pts_q[cnt_q][k] <= (2'(k) == EDGE_AXIS[cmd.edge_idx]) ? weight :
					(CORNER_MASK[k][EDGE_FROM[cmd.edge_idx]] ? ONE_P : '0);
			end
		end
	end

	// next-vertex selection along shared faces
	always_comb begin
		for (int j = 0; j < NPTS; j++) begin
			avail[j] = (3'(j) < cnt_q) && !used_q[j];
		end
		for (int a = 0; a < 3; a++) begin
			face[a] = (cur_q[a] == '0) || (cur_q[a] == ONE_P);
			for (int j = 0; j < NPTS; j++) begin
				m[a][j] = avail[j] && (pts_q[j][a] == cur_q[a]);
			end
		end
	end

	always_comb begin
		logic found;
		found    = 1'b0;
		pick_vec = '0;
		if (cmd.emit_first) begin
			pick_vec = NPTS'(1);
		end else begin
			if (!cmd.emit_last) begin
				for (int a = 0; a < 3; a++) begin
					if (!found && face[a] && (|m[a])) begin
						pick_vec = m[a];
						found    = 1'b1;
					end
				end
			end
			if (!found) begin
				pick_vec = avail;
			end
		end
		sel = '0;
		for (int j = NPTS - 1; j >= 0; j--) begin
			if (pick_vec[j]) begin
				sel = 3'(j);
			end
		end
	end

	assign st.out_free = !out_valid_q || !out_stall;
	assign st.cnt      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1    <= 1'b0;
			cnt_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mac_v_s1 <= cmd.mac;
			if (cmd.load) begin
				cnt_q  <= '0;
				used_q <= '0;
			end else if (cmd.pt_wr && cnt_q != 3'(NPTS)) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (cmd.emit) begin
				used_q[sel] <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cur_q       <= pts_q[sel];
			plane_tag   <= tag_q;
			vertex_x    <= CW'(pts_q[sel][0]);
			vertex_y    <= CW'(pts_q[sel][1]);
			vertex_z    <= CW'(pts_q[sel][2]);
			last_vertex <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- design/pcsp_ctrl.sv -----
// Controller: sequences distance, edge division and vertex chaining for one plane.
`default_nettype none

module pcsp_ctrl import pcsp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire pcsp_stat_t st,
	output pcsp_cmd_t       cmd
);

	localparam int DCW = $clog2(FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIST, ST_DRAIN, ST_EDGE_RD, ST_EDGE_LD, ST_DIV, ST_PT_WR, ST_CHAIN
	} state_t;

	state_t         state_q;
	logic [2:0]     corner_q;
	logic [1:0]     axis_q;
	logic [3:0]     edge_q;
	logic [DCW-1:0] div_q;
	logic [2:0]     emit_q;

	always_comb begin
		cmd            = '0;
		cmd.corner     = corner_q;
		cmd.axis       = axis_q;
		cmd.edge_idx   = edge_q;
		cmd.mac_first  = (axis_q == 2'd0);
		cmd.mac_last   = (axis_q == LAST_AXIS);
		cmd.emit_first = (emit_q == 3'd0);
		cmd.emit_last  = (emit_q == st.cnt - 3'd1);
		case (state_q)
			ST_IDLE:    cmd.load     = in_valid;
			ST_DIST:    cmd.mac      = 1'b1;
			ST_EDGE_RD: cmd.rd       = 1'b1;
			ST_EDGE_LD: cmd.div_init = 1'b1;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_PT_WR:   cmd.pt_wr    = 1'b1;
			ST_CHAIN:   cmd.emit     = (st.cnt != 3'd0) && st.out_free;
			default:    ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= '0;
			axis_q   <= '0;
			edge_q   <= '0;
			div_q    <= '0;
			emit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_DIST;
						corner_q <= '0;
						axis_q   <= '0;
					end
				end
				ST_DIST: begin
					if (axis_q == LAST_AXIS) begin
						axis_q   <= '0;
						corner_q <= corner_q + 3'd1;
						if (corner_q == LAST_CORNER) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					edge_q  <= '0;
					state_q <= ST_EDGE_RD;
				end
				ST_EDGE_RD: begin
					if (st.differ) begin
						state_q <= ST_EDGE_LD;
					end else if (edge_q == LAST_EDGE) begin
						emit_q  <= '0;
						state_q <= ST_CHAIN;
					end else begin
						edge_q <= edge_q + 4'd1;
					end
				end
				ST_EDGE_LD: begin
					div_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					div_q <= div_q + DCW'(1);
					if (div_q == DCW'(FRAC_BITS - 1)) begin
						state_q <= ST_PT_WR;
					end
				end
				ST_PT_WR: begin
					if (edge_q == LAST_EDGE) begin
						emit_q  <= '0;
						state_q <= ST_CHAIN;
					end else begin
						edge_q  <= edge_q + 4'd1;
						state_q <= ST_EDGE_RD;
					end
				end
				ST_CHAIN: begin
					if (st.cnt == 3'd0) begin
						state_q <= ST_IDLE;
					end else if (st.out_free) begin
						emit_q <= emit_q + 3'd1;
						if (cmd.emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/plane_cube_slice_polygon.sv -----
// Top level of the plane / unit cube cross-section polygon block.
//
// One input transaction describes a plane (origin, Q1.FRAC_BITS unsigned; direction,
// Q1.15 signed). The block returns the polygon where that plane cuts the unit cube,
// one output transaction per vertex, 3 to 6 of them, ordered by walking shared cube
// faces, each tagged with the plane number; last_vertex marks the final one. A plane
// that misses the cube, or has a zero direction, returns nothing. Corners with zero
// distance count as outside. Planes are processed one at a time, in steps: the corner
// distances from one shared multiplier, a drain step, a sweep over the cube edges, a
// restoring divider that produces one weight bit per cycle for each cut edge (plus a
// load and a store step), the vertices emitted one at a time, waiting while the output
// is stalled, and an idle state to take the next plane. The last vertex sits in the
// output register while the next plane is taken in.
`default_nettype none

module plane_cube_slice_polygon import pcsp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [TW-1:0]        plane_number,
	input  wire logic [CW-1:0]        origin_x,
	input  wire logic [CW-1:0]        origin_y,
	input  wire logic [CW-1:0]        origin_z,
	input  wire logic signed [NW-1:0] normal_x,
	input  wire logic signed [NW-1:0] normal_y,
	input  wire logic signed [NW-1:0] normal_z,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [TW-1:0]             plane_tag,
	output logic [CW-1:0]             vertex_x,
	output logic [CW-1:0]             vertex_y,
	output logic [CW-1:0]             vertex_z,
	output logic                      last_vertex
);

	pcsp_cmd_t  cmd;
	pcsp_stat_t st;

	// sequencer: owns all loop counters, datapath only sees commands
	pcsp_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	pcsp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.plane_number (plane_number),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.origin_z     (origin_z),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.plane_tag    (plane_tag),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.last_vertex  (last_vertex)
	);

endmodule

`default_nettype wire

// ----- design/pcsp_check.sv -----
// Port-level checks for the slice block, bound to the top level.
`default_nettype none

module pcsp_check import pcsp_pkg::*; (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire logic [TW-1:0] plane_tag,
	input wire logic [CW-1:0] vertex_x,
	input wire logic [CW-1:0] vertex_y,
	input wire logic [CW-1:0] vertex_z,
	input wire logic          last_vertex
);

	// stalled vertex holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plane_tag) && $stable(vertex_x)
			&& $stable(vertex_y) && $stable(vertex_z) && $stable(last_vertex))
		else $error("stalled output vertex changed");

	// one plane at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous plane in work");

	// no new plane while a polygon is still open
	a_open_poly: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_vertex |-> in_stall)
		else $error("input ready with polygon unfinished");

endmodule

bind plane_cube_slice_polygon pcsp_check u_check (.*);

`default_nettype wire

// ----- tb/tb_plane_cube_slice_polygon.sv -----
// Self-checking testbench for the plane / unit cube cross-section polygon block.
`default_nettype none

module tb_plane_cube_slice_polygon;
	import pcsp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam int N_RAND = 290;

	// cube corner positions, bit per axis
	localparam logic [2:0] CPOS [8] = '{3'b000, 3'b001, 3'b011, 3'b010,
		3'b100, 3'b101, 3'b111, 3'b110};
	localparam logic [2:0] E_FROM [12] = '{3'd0, 3'd3, 3'd7, 3'd4, 3'd0, 3'd4,
		3'd5, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3};
	localparam logic [2:0] E_TO [12] = '{3'd1, 3'd2, 3'd6, 3'd5, 3'd3, 3'd7,
		3'd6, 3'd2, 3'd4, 3'd5, 3'd6, 3'd7};

	typedef struct packed {
		logic [TW-1:0]        tag;
		logic [CW-1:0]        ox, oy, oz;
		logic signed [NW-1:0] nx, ny, nz;
	} plane_t;

	typedef struct packed {
		logic [TW-1:0] tag;
		logic [CW-1:0] vx, vy, vz;
		logic          last;
	} vertex_t;

	// directed row: plane plus, optionally, the expected vertex count
	// (-1 means the predictor alone decides)
	typedef struct {
		plane_t p;
		int     n_exp;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [TW-1:0] plane_number = '0;
	logic [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [NW-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic out_valid;
	logic out_stall = 1;
	logic [TW-1:0] plane_tag;
	logic [CW-1:0] vertex_x, vertex_y, vertex_z;
	logic last_vertex;

	vertex_t expected_vertices[$];
	int mismatches = 0;
	int count_errors = 0;
	bit sending_done = 0;
	bit hold_request = 0;	// ask the receiver for a long hold-off

	plane_cube_slice_polygon #(.FRAC_BITS(FRAC)) u_top (
		.clk, .arst_n, .in_valid, .in_stall, .plane_number,
		.origin_x, .origin_y, .origin_z, .normal_x, .normal_y, .normal_z,
		.out_valid, .out_stall, .plane_tag, .vertex_x, .vertex_y, .vertex_z,
		.last_vertex
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#8_000_000;
		$display("[plane_cube_slice_polygon] ERROR");
		$finish;
	end

	// floor(a * ONE / s), restoring style
	function automatic longint slice_weight(longint a, longint s);
		longint q, r;
		q = 0;
		r = a;
		if (s == 0) return 0;
		if (a >= s) return ONE;
		for (int i = 0; i < FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= s) begin
				r = r - s;
				q = q | 1;
			end
		end
		return q;
	endfunction

	// Computes the cross-section polygon and queues one vertex per corner of it.
	// Returns the number of vertices queued.
	function automatic int predict_polygon(plane_t p);
		longint org[3], nrm[3], cdist[8], pts[12][3];
		bit outside[8], taken[12];
		int order[12];
		int cnt, emit, cur, pick;
		longint ma, mb, v, d;
		vertex_t vtx;
		cnt = 0;
		org[0] = p.ox; org[1] = p.oy; org[2] = p.oz;
		nrm[0] = p.nx; nrm[1] = p.ny; nrm[2] = p.nz;
		for (int c = 0; c < 8; c++) begin
			d = 0;
			for (int k = 0; k < 3; k++)
				d += nrm[k] * ((CPOS[c][k] ? ONE : 0) - org[k]);
			cdist[c] = d;
			outside[c] = d >= 0;	// zero counts as outside
		end
		for (int e = 0; e < 12; e++) begin
			if (outside[E_FROM[e]] != outside[E_TO[e]]) begin
				ma = cdist[E_FROM[e]] < 0 ? -cdist[E_FROM[e]] : cdist[E_FROM[e]];
				mb = cdist[E_TO[e]] < 0 ? -cdist[E_TO[e]] : cdist[E_TO[e]];
				for (int k = 0; k < 3; k++)
					pts[cnt][k] = CPOS[E_FROM[e]][k] ? ONE : 0;
				pts[cnt][e / 4] = slice_weight(ma, ma + mb);
				taken[cnt] = 0;
				cnt++;
			end
		end
		if (cnt == 0) return 0;
		// chain along shared faces; fall back to first unused
		order[0] = 0;
		taken[0] = 1;
		for (int k = 1; k < cnt; k++) begin
			cur = order[k - 1];
			pick = -1;
			if (k < cnt - 1) begin
				for (int ax = 0; ax < 3 && pick < 0; ax++) begin
					v = pts[cur][ax];
					if (v == 0 || v == ONE)
						for (int j = 0; j < cnt; j++)
							if (pick < 0 && !taken[j] && pts[j][ax] == v) pick = j;
				end
			end
			if (pick < 0)
				for (int j = 0; j < cnt; j++)
					if (pick < 0 && !taken[j]) pick = j;
			order[k] = pick;
			taken[pick] = 1;
		end
		emit = cnt > NPTS ? NPTS : cnt;
		for (int k = 0; k < emit; k++) begin
			vtx.tag = p.tag;
			vtx.vx = pts[order[k]][0][CW-1:0];
			vtx.vy = pts[order[k]][1][CW-1:0];
			vtx.vz = pts[order[k]][2][CW-1:0];
			vtx.last = (k == emit - 1);
			expected_vertices = {expected_vertices, vtx};
		end
		return emit;
	endfunction

	function automatic plane_t random_plane();
		plane_t p;
		int mode;
		p.tag = TW'($urandom);
		mode = $urandom_range(0, 9);
		// mostly origins inside the cube so the plane cuts it
		p.ox = (mode == 0) ? CW'($urandom) : CW'($urandom_range(0, 65536));
		p.oy = (mode == 1) ? CW'($urandom) : CW'($urandom_range(0, 65536));
		p.oz = (mode == 2) ? CW'($urandom) : CW'($urandom_range(0, 65536));
		p.nx = NW'($urandom);
		p.ny = NW'($urandom);
		p.nz = NW'($urandom);
		// axis-aligned and grid-valued planes hit degenerate cases
		if (mode == 3) begin
			p.ny = '0;
			p.nz = '0;
		end
		if (mode == 4) begin
			p.ox = CW'($urandom_range(0, 4) * 16384);
			p.oy = CW'($urandom_range(0, 4) * 16384);
			p.oz = CW'($urandom_range(0, 4) * 16384);
			p.nx = NW'(int'($urandom_range(0, 4)) * 8192 - 16384);
			p.ny = NW'(int'($urandom_range(0, 4)) * 8192 - 16384);
			p.nz = NW'(int'($urandom_range(0, 4)) * 8192 - 16384);
		end
		return p;
	endfunction

	// drive one plane, wait for the transaction to be taken, then drop valid
	task automatic send_plane(plane_t p, output int n_pred);
		plane_number <= p.tag;
		origin_x <= p.ox;
		origin_y <= p.oy;
		origin_z <= p.oz;
		normal_x <= p.nx;
		normal_y <= p.ny;
		normal_z <= p.nz;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_pred = predict_polygon(p);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic run_plane(plane_t p, int n_exp);
		int got;
		send_plane(p, got);
		if (n_exp >= 0 && got != n_exp) begin
			count_errors++;
			$display("plane %0d: expected %0d vertices, predictor gives %0d",
				p.tag, n_exp, got);
		end
	endtask

	task automatic idle_sender();
		int gap;
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stimulus
	initial begin
		row_t rows[$];
		row_t r;
		plane_t p;
		int k;
		int n_pred;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: count is typed in only where obvious
		r.n_exp = 4; r.p = '{8'h00, 17'd32768, 17'd32768, 17'd32768, 16'sd32767, 16'sd0,
			16'sd0};
		rows = {rows, r};
		r.n_exp = 4; r.p = '{8'hFF, 17'd32768, 17'd32768, 17'd32768, 16'sd0, -16'sd32768,
			16'sd0};
		rows = {rows, r};
		r.n_exp = 4; r.p = '{8'h5A, 17'd1, 17'd65535, 17'd100, 16'sd0, 16'sd0, 16'sd32767};
		rows = {rows, r};
		r.n_exp = 0; r.p = '{8'hA5, 17'd12345, 17'd100, 17'd200, 16'sd0, 16'sd0, 16'sd0};
		rows = {rows, r};	// zero direction
		r.n_exp = 0; r.p = '{8'h11, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'sd100, 16'sd100,
			16'sd100};	// origin beyond the cube, plane misses it
		rows = {rows, r};
		r.n_exp = -1; r.p = '{8'h22, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, -16'sd32768,
			-16'sd32768, -16'sd32768};
		rows = {rows, r};
		r.n_exp = 6; r.p = '{8'h33, 17'd32768, 17'd32768, 17'd32768, 16'sd16384, 16'sd16384,
			16'sd16384};	// hexagon
		rows = {rows, r};
		r.n_exp = 3; r.p = '{8'h44, 17'd16384, 17'd0, 17'd0, 16'sd1000, 16'sd1000,
			16'sd1000};	// triangle at a corner
		rows = {rows, r};
		r.n_exp = -1; r.p = '{8'h55, 17'd0, 17'd0, 17'd0, 16'sd1, 16'sd1, 16'sd1};
		rows = {rows, r};	// corner on the plane, zero distance
		r.n_exp = 3; r.p = '{8'h66, 17'd65536, 17'd65536, 17'd65536, 16'sd1, 16'sd1, 16'sd1};
		rows = {rows, r};	// far corner counts as outside: three points all on it
		r.n_exp = -1; r.p = '{8'h77, 17'd0, 17'd0, 17'd0, 16'sd1, -16'sd1, 16'sd0};
		rows = {rows, r};	// plane through an edge and diagonal
		r.n_exp = -1; r.p = '{8'h88, 17'd65536, 17'd0, 17'd32768, -16'sd32768, 16'sd32767,
			-16'sd1};
		rows = {rows, r};
		r.n_exp = -1; r.p = '{8'h99, 17'd32768, 17'd0, 17'd65536, 16'sd12000, -16'sd5,
			-16'sd9000};
		rows = {rows, r};
		r.n_exp = 4; r.p = '{8'h01, 17'd0, 17'd0, 17'd1, 16'sd0, 16'sd0, -16'sd32768};
		rows = {rows, r};
		foreach (rows[i]) begin
			run_plane(rows[i].p, rows[i].n_exp);
			idle_sender();
		end

		// random part, with two pressure phases along the way
		for (k = 0; k < N_RAND; k++) begin
			if (k == 60) begin
				// pause until the block has drained
				in_valid <= 0;
				while (expected_vertices.size() != 0) @(posedge clk);
				repeat (200) @(posedge clk);
			end
			if (k == 120) hold_request = 1;	// receiver holds, sender keeps going
			p = random_plane();
			send_plane(p, n_pred);
			if (k < 120 || k > 130) idle_sender();
		end
		in_valid <= 0;
		sending_done = 1;
	end

	// Receiver: random stall, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				out_stall <= 1;
				repeat (1500) @(posedge clk);
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				out_stall <= 1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Checker: one vertex per accepted output transaction
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected vertex tag %0d (%0d,%0d,%0d) last %0b",
						plane_tag, vertex_x, vertex_y, vertex_z, last_vertex);
			end else begin
				want = expected_vertices.pop_front();
				if (want.tag !== plane_tag || want.vx !== vertex_x ||
						want.vy !== vertex_y || want.vz !== vertex_z ||
						want.last !== last_vertex) begin
					mismatches++;
					if (mismatches <= 10)
						$display("vertex mismatch: want %0d (%0d,%0d,%0d) %0b, got %0d (%0d,%0d,%0d) %0b",
							want.tag, want.vx, want.vy, want.vz, want.last,
							plane_tag, vertex_x, vertex_y, vertex_z, last_vertex);
				end
			end
		end
	end

	// End of run
	initial begin
		wait (sending_done);
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && count_errors == 0 && expected_vertices.size() == 0)
			$display("[plane_cube_slice_polygon] OK");
		else
			$display("[plane_cube_slice_polygon] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/pcsp_pkg.sv
design/pcsp_dp.sv
design/pcsp_ctrl.sv
design/plane_cube_slice_polygon.sv
design/pcsp_check.sv
tb/tb_plane_cube_slice_polygon.sv
